/* src/chsup_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package chsup_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned GRACE_W  = 16;
   localparam int unsigned VOLT_W   = 13;
   localparam int unsigned CURR_W   = 12;
   localparam int unsigned CODE_W   = 4;
   localparam int unsigned PACK_W   = 20;
   localparam int unsigned SCALE_W  = 8;
   localparam int unsigned PROD_W   = VOLT_W + SCALE_W;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned REG_IDX_W  = 3;

   localparam logic [SCALE_W-1:0] DoneScale = 8'd200;

   localparam logic [VOLT_W-1:0]  MIN_INPUT_RESET   = 13'd40;
   localparam logic [VOLT_W-1:0]  OVERVOLT_RESET    = 13'd1980;
   localparam logic [CURR_W-1:0]  OVERCURR_RESET    = 12'd2075;
   localparam logic [GRACE_W-1:0] DWELL_RESET       = 16'd500;
   localparam logic [GRACE_W-1:0] PRE_GRACE_RESET   = 16'd1000;
   localparam logic [GRACE_W-1:0] OC_GRACE_RESET    = 16'd500;
   localparam logic [CODE_W-1:0]  READY_CODE_RESET  = 4'd2;
   localparam logic [CODE_W-1:0]  FAULT_CODE_RESET  = 4'd3;

   typedef enum logic [2:0] {
      MODE_INIT  = 3'd0,
      MODE_TEST  = 3'd1,
      MODE_READY = 3'd2,
      MODE_START = 3'd3,
      MODE_FAIL  = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      CAUSE_NONE      = 3'd0,
      CAUSE_PRECHARGE = 3'd1,
      CAUSE_OVERVOLT  = 3'd2,
      CAUSE_FAULT     = 3'd3,
      CAUSE_OVERCURR  = 3'd4,
      CAUSE_BAD_STATE = 3'd5
   } cause_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_MIN_INPUT  = 3'd0,
      REG_OVERVOLT   = 3'd1,
      REG_OVERCURR   = 3'd2,
      REG_DWELL      = 3'd3,
      REG_PRE_GRACE  = 3'd4,
      REG_OC_GRACE   = 3'd5,
      REG_READY_CODE = 3'd6,
      REG_FAULT_CODE = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [VOLT_W-1:0]  min_input_raw;
      logic [VOLT_W-1:0]  overvoltage_raw;
      logic [CURR_W-1:0]  overcurrent_raw;
      logic [GRACE_W-1:0] dwell_ms;
      logic [GRACE_W-1:0] precharge_grace_ms;
      logic [GRACE_W-1:0] overcurrent_grace_ms;
      logic [CODE_W-1:0]  ready_handle_code;
      logic [CODE_W-1:0]  fault_status_code;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]  now_ms;
      logic               button_level;
      logic               precharge_ok;
      logic [VOLT_W-1:0]  dc_voltage_raw;
      logic [CURR_W-1:0]  dc_current_raw;
      logic [CODE_W-1:0]  handle_code;
      logic [CODE_W-1:0]  status_code;
      logic [PACK_W-1:0]  pack_mv;
      logic               start_cmd;
      logic               stop_cmd;
      logic               reset_cmd;
   } item_type;

   typedef struct packed {
      mode_type  charge_state;
      logic      state_changed;
      cause_type fail_cause;
      logic      output_enable;
   } result_type;

endpackage

`default_nettype wire

/* src/charger_supervisor_fsm_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Charger supervisor: each request is one evaluation tick and yields exactly one
// response with the state after the tick (init, test, ready, charging, fail), a
// state-changed flag, the fail cause of that tick and the output enable. One
// request is taken every clock cycle while responses are taken; a request lands in
// the input register at the edge that accepts it and its response is loaded into the
// response register at the edge on which the request fires, which waits while an
// untaken response is held. The supervisor state updates combinationally between
// those two registers and is registered with the response, so the rate is set by
// that next-state logic and stays one tick per cycle. Registers sit on the APB-style
// port at byte address 4*index and should be written only while no tick is in flight.
module charger_supervisor_fsm_core (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [chsup_pkg::TIME_W-1:0]      req_now_ms,
   input  wire logic                              req_button_level,
   input  wire logic                              req_precharge_ok,
   input  wire logic [chsup_pkg::VOLT_W-1:0]      req_dc_voltage_raw,
   input  wire logic [chsup_pkg::CURR_W-1:0]      req_dc_current_raw,
   input  wire logic [chsup_pkg::CODE_W-1:0]      req_handle_code,
   input  wire logic [chsup_pkg::CODE_W-1:0]      req_status_code,
   input  wire logic [chsup_pkg::PACK_W-1:0]      req_pack_mv,
   input  wire logic                              req_start_cmd,
   input  wire logic                              req_stop_cmd,
   input  wire logic                              req_reset_cmd,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [2:0]                             rsp_charge_state,
   output logic                                   rsp_state_changed,
   output logic [2:0]                             rsp_fail_cause,
   output logic                                   rsp_output_enable,

   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [chsup_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [chsup_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [chsup_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                   csr_pready
);

   chsup_pkg::cfg_type    cfg;
   chsup_pkg::item_type   item_ff;
   chsup_pkg::result_type result_ff;
   chsup_pkg::result_type step_result;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic                  fire;
   logic                  req_take;

   chsup_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   chsup_step u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   assign fire         = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || fire;
   assign req_take     = req_valid && req_ready;
   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_ready);

   assign rsp_valid         = out_valid_ff;
   assign rsp_charge_state  = result_ff.charge_state;
   assign rsp_state_changed = result_ff.state_changed;
   assign rsp_fail_cause    = result_ff.fail_cause;
   assign rsp_output_enable = result_ff.output_enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.now_ms         <= req_now_ms;
         item_ff.button_level   <= req_button_level;
         item_ff.precharge_ok   <= req_precharge_ok;
         item_ff.dc_voltage_raw <= req_dc_voltage_raw;
         item_ff.dc_current_raw <= req_dc_current_raw;
         item_ff.handle_code    <= req_handle_code;
         item_ff.status_code    <= req_status_code;
         item_ff.pack_mv        <= req_pack_mv;
         item_ff.start_cmd      <= req_start_cmd;
         item_ff.stop_cmd       <= req_stop_cmd;
         item_ff.reset_cmd      <= req_reset_cmd;
      end
      if (fire) begin
         result_ff <= step_result;
      end
   end

   a_enable_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_output_enable ==
                     (result_ff.charge_state == chsup_pkg::MODE_START)))
      else $error("output enable disagrees with charging state");

   a_cause_means_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && result_ff.fail_cause != chsup_pkg::CAUSE_NONE) |->
      (result_ff.charge_state == chsup_pkg::MODE_FAIL && rsp_state_changed))
      else $error("fail cause reported without a change into fail");

   a_stalled_request_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> (in_valid_ff && $stable(item_ff)))
      else $error("stalled request lost from input register");

   a_fire_fills_output: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("evaluated request produced no response");

endmodule

`default_nettype wire

/* src/chsup_csr.sv */
`timescale 1ns / 1ps
`default_nettype none

module chsup_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [chsup_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [chsup_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [chsup_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                      csr_pready,
   output chsup_pkg::cfg_type                        cfg
);

   chsup_pkg::cfg_type       cfg_ff;
   chsup_pkg::cfg_type       cfg_in;
   chsup_pkg::reg_index_type reg_idx;
   logic                     write_en;

   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = chsup_pkg::reg_index_type'(csr_paddr[chsup_pkg::CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_idx)
            chsup_pkg::REG_MIN_INPUT:  cfg_in.min_input_raw = csr_pwdata[12:0];
            chsup_pkg::REG_OVERVOLT:   cfg_in.overvoltage_raw = csr_pwdata[12:0];
            chsup_pkg::REG_OVERCURR:   cfg_in.overcurrent_raw = csr_pwdata[11:0];
            chsup_pkg::REG_DWELL:      cfg_in.dwell_ms = csr_pwdata[15:0];
            chsup_pkg::REG_PRE_GRACE:  cfg_in.precharge_grace_ms = csr_pwdata[15:0];
            chsup_pkg::REG_OC_GRACE:   cfg_in.overcurrent_grace_ms = csr_pwdata[15:0];
            chsup_pkg::REG_READY_CODE: cfg_in.ready_handle_code = csr_pwdata[3:0];
            chsup_pkg::REG_FAULT_CODE: cfg_in.fault_status_code = csr_pwdata[3:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         chsup_pkg::REG_MIN_INPUT:  csr_prdata = {19'd0, cfg_ff.min_input_raw};
         chsup_pkg::REG_OVERVOLT:   csr_prdata = {19'd0, cfg_ff.overvoltage_raw};
         chsup_pkg::REG_OVERCURR:   csr_prdata = {20'd0, cfg_ff.overcurrent_raw};
         chsup_pkg::REG_DWELL:      csr_prdata = {16'd0, cfg_ff.dwell_ms};
         chsup_pkg::REG_PRE_GRACE:  csr_prdata = {16'd0, cfg_ff.precharge_grace_ms};
         chsup_pkg::REG_OC_GRACE:   csr_prdata = {16'd0, cfg_ff.overcurrent_grace_ms};
         chsup_pkg::REG_READY_CODE: csr_prdata = {28'd0, cfg_ff.ready_handle_code};
         chsup_pkg::REG_FAULT_CODE: csr_prdata = {28'd0, cfg_ff.fault_status_code};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_input_raw        <= chsup_pkg::MIN_INPUT_RESET;
         cfg_ff.overvoltage_raw      <= chsup_pkg::OVERVOLT_RESET;
         cfg_ff.overcurrent_raw      <= chsup_pkg::OVERCURR_RESET;
         cfg_ff.dwell_ms             <= chsup_pkg::DWELL_RESET;
         cfg_ff.precharge_grace_ms   <= chsup_pkg::PRE_GRACE_RESET;
         cfg_ff.overcurrent_grace_ms <= chsup_pkg::OC_GRACE_RESET;
         cfg_ff.ready_handle_code    <= chsup_pkg::READY_CODE_RESET;
         cfg_ff.fault_status_code    <= chsup_pkg::FAULT_CODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* src/chsup_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module chsup_step (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  chsup_pkg::item_type       item,
   input  chsup_pkg::cfg_type        cfg,
   output chsup_pkg::result_type     result
);

   chsup_pkg::mode_type  mode_ff;
   chsup_pkg::mode_type  mode_in;
   chsup_pkg::cause_type cause;

   logic [chsup_pkg::TIME_W-1:0] last_change_ff;
   logic [chsup_pkg::TIME_W-1:0] last_change_in;
   logic                         prev_button_ff;
   logic                         pl_armed_ff;
   logic                         pl_armed_in;
   logic [chsup_pkg::TIME_W-1:0] pl_time_ff;
   logic [chsup_pkg::TIME_W-1:0] pl_time_in;
   logic                         oc_armed_ff;
   logic                         oc_armed_in;
   logic [chsup_pkg::TIME_W-1:0] oc_time_ff;
   logic [chsup_pkg::TIME_W-1:0] oc_time_in;
   logic                         start_pending_ff;
   logic                         start_pending_in;
   logic                         reset_pending_ff;
   logic                         reset_pending_in;

   logic                         start_p;
   logic                         reset_p;
   logic                         pressed;
   logic                         go;
   logic [chsup_pkg::TIME_W-1:0] since_change;
   logic [chsup_pkg::TIME_W-1:0] since_pl;
   logic [chsup_pkg::TIME_W-1:0] since_oc;
   logic                         pl_trip;
   logic                         over_volt;
   logic                         fault;
   logic                         over_curr;
   logic                         oc_trip;
   logic [chsup_pkg::PROD_W-1:0] charge_level;
   logic                         done;
   logic                         ready_go;
   logic                         fail_go;
   logic                         run_go;

   // apply command pulses in order: start, stop, reset
   always_comb begin
      start_p = start_pending_ff;
      reset_p = reset_pending_ff;
      if (item.start_cmd) begin
         start_p = 1'b1;
      end
      if (item.stop_cmd) begin
         start_p = 1'b0;
      end
      if (item.reset_cmd && mode_ff == chsup_pkg::MODE_FAIL) begin
         reset_p = 1'b1;
         start_p = 1'b0;
      end
   end

   assign pressed      = item.button_level && !prev_button_ff;
   assign since_change = item.now_ms - last_change_ff;
   assign since_pl     = item.now_ms - pl_time_ff;
   assign since_oc     = item.now_ms - oc_time_ff;
   assign go           = (mode_ff == chsup_pkg::MODE_FAIL) ||
                         (since_change >= {16'd0, cfg.dwell_ms});
   assign pl_trip      = !item.precharge_ok && pl_armed_ff &&
                         (since_pl > {16'd0, cfg.precharge_grace_ms});
   assign over_volt    = item.dc_voltage_raw > cfg.overvoltage_raw;
   assign fault        = item.status_code == cfg.fault_status_code;
   assign over_curr    = item.dc_current_raw > cfg.overcurrent_raw;
   assign oc_trip      = over_curr && oc_armed_ff &&
                         (since_oc > {16'd0, cfg.overcurrent_grace_ms});
   assign charge_level = {8'd0, item.dc_voltage_raw} * {13'd0, chsup_pkg::DoneScale};
   assign done         = charge_level >= {1'b0, item.pack_mv};
   assign ready_go     = go && mode_ff == chsup_pkg::MODE_READY && item.precharge_ok &&
                         (pressed || start_p);
   assign fail_go      = go && mode_ff == chsup_pkg::MODE_FAIL && item.precharge_ok &&
                         reset_p;
   assign run_go       = go && mode_ff == chsup_pkg::MODE_START;

   always_comb begin
      mode_in = mode_ff;
      cause   = chsup_pkg::CAUSE_NONE;
      if (go) begin
         unique case (mode_ff)
            chsup_pkg::MODE_INIT: begin
               mode_in = (item.dc_voltage_raw < cfg.min_input_raw) ?
                         chsup_pkg::MODE_TEST : chsup_pkg::MODE_READY;
            end
            chsup_pkg::MODE_TEST: begin
               if (item.dc_voltage_raw > cfg.min_input_raw &&
                   item.handle_code == cfg.ready_handle_code) begin
                  mode_in = chsup_pkg::MODE_READY;
               end
            end
            chsup_pkg::MODE_READY: begin
               if (item.precharge_ok && (pressed || start_p)) begin
                  mode_in = chsup_pkg::MODE_START;
               end
            end
            chsup_pkg::MODE_START: begin
               if (pl_trip) begin
                  mode_in = chsup_pkg::MODE_FAIL;
                  cause   = chsup_pkg::CAUSE_PRECHARGE;
               end else if (over_volt) begin
                  mode_in = chsup_pkg::MODE_FAIL;
                  cause   = chsup_pkg::CAUSE_OVERVOLT;
               end else if (fault) begin
                  mode_in = chsup_pkg::MODE_FAIL;
                  cause   = chsup_pkg::CAUSE_FAULT;
               end else if (oc_trip) begin
                  mode_in = chsup_pkg::MODE_FAIL;
                  cause   = chsup_pkg::CAUSE_OVERCURR;
               end else if (done) begin
                  mode_in = chsup_pkg::MODE_READY;
               end
            end
            chsup_pkg::MODE_FAIL: begin
               if (item.precharge_ok && reset_p) begin
                  mode_in = chsup_pkg::MODE_READY;
               end
            end
            default: begin
               mode_in = chsup_pkg::MODE_FAIL;
               cause   = chsup_pkg::CAUSE_BAD_STATE;
            end
         endcase
      end
   end

   always_comb begin
      start_pending_in = ready_go ? 1'b0 : start_p;
      reset_pending_in = fail_go ? 1'b0 : reset_p;
      pl_armed_in      = pl_armed_ff;
      pl_time_in       = pl_time_ff;
      oc_armed_in      = oc_armed_ff;
      oc_time_in       = oc_time_ff;
      if (run_go) begin
         if (pl_trip) begin
            pl_armed_in = 1'b0;
         end else begin
            if (!item.precharge_ok) begin
               if (!pl_armed_ff) begin
                  pl_armed_in = 1'b1;
                  pl_time_in  = item.now_ms;
               end
            end else begin
               pl_armed_in = 1'b0;
            end
            if (!over_volt && !fault) begin
               if (oc_trip) begin
                  oc_armed_in = 1'b0;
               end else if (over_curr) begin
                  if (!oc_armed_ff) begin
                     oc_armed_in = 1'b1;
                     oc_time_in  = item.now_ms;
                  end
               end else begin
                  oc_armed_in = 1'b0;
               end
            end
         end
      end
      last_change_in = (mode_in != mode_ff) ? item.now_ms : last_change_ff;
   end

   always_comb begin
      result.charge_state  = mode_in;
      result.state_changed = mode_in != mode_ff;
      result.fail_cause    = cause;
      result.output_enable = mode_in == chsup_pkg::MODE_START;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= chsup_pkg::MODE_INIT;
         last_change_ff   <= '0;
         prev_button_ff   <= 1'b1;
         pl_armed_ff      <= 1'b0;
         pl_time_ff       <= '0;
         oc_armed_ff      <= 1'b0;
         oc_time_ff       <= '0;
         start_pending_ff <= 1'b0;
         reset_pending_ff <= 1'b0;
      end else if (fire) begin
         mode_ff          <= mode_in;
         last_change_ff   <= last_change_in;
         prev_button_ff   <= item.button_level;
         pl_armed_ff      <= pl_armed_in;
         pl_time_ff       <= pl_time_in;
         oc_armed_ff      <= oc_armed_in;
         oc_time_ff       <= oc_time_in;
         start_pending_ff <= start_pending_in;
         reset_pending_ff <= reset_pending_in;
      end
   end

endmodule

`default_nettype wire
